// File: hdl/frozen_interval_table_assert.svh
// Assertion macros for the interval table.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef FROZEN_INTERVAL_TABLE_ASSERT_SVH
`define FROZEN_INTERVAL_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define FIT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frozen_interval_table: same-cycle check failed");

`define FIT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frozen_interval_table: next-cycle check failed");

`else

`define FIT_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define FIT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/fit_pkg.sv
`default_nettype none

package fit_pkg;

   localparam int MAX_INTERVALS_DEF = 16;
   localparam int DEPTH_BITS_DEF = 16;

   localparam int FIELD_W = 16;
   localparam int COUNT_FIELD_W = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 56;

   // The fraction is unsigned Q1.15.
   localparam int FRAC_BITS = 15;
   localparam logic [FIELD_W-1:0] FRAC_ONE = 16'h8000;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADD_END,
      ST_QRY_END,
      ST_DIV,
      ST_DONE
   } fit_state_type;

endpackage

`default_nettype wire

// File: hdl/frozen_interval_table.sv
// Transactions are handled one at a time: each one scans the N stored intervals (up to
// MAX_INTERVALS) through the single read port of the interval memory, then a query
// whose fraction is strictly between zero and one runs a bit-serial divide.
// A result waits in an output register while the next transaction is taken.
// Reset is synchronous and active high; it empties the table, memory contents are kept.
`default_nettype none

`include "frozen_interval_table_assert.svh"

module frozen_interval_table #(
   parameter int MAX_INTERVALS = fit_pkg::MAX_INTERVALS_DEF,
   parameter int DEPTH_BITS = fit_pkg::DEPTH_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] upper_depth, [31:16] lower_depth
   input  wire logic [fit_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] mode
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] frozen_fraction, [31:16] shallowest_top, [47:32] deepest_bottom,
   // [52:48] entry_count, [53] overflow, [55:54] zero
   output logic [fit_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   localparam int DW = DEPTH_BITS;
   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int SUM_W = DW + CW + 1;
   localparam int FW = fit_pkg::FIELD_W;

   fit_pkg::fit_state_type state_ff, state_in;

   // Transaction payload.
   logic                    mode_ff;
   logic [DW-1:0]           new_top_ff;
   logic [DW-1:0]           new_bot_ff;
   logic [DW-1:0]           span_ff;
   logic                    span_ok_ff;

   // Scan control.
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           rd_cnt_ff;
   logic                    pend_ff;
   logic [CW-1:0]           kept_ff;
   logic                    match_ff;
   logic                    any_ff;
   logic                    ovl_vld_ff;

   // Scan data.
   logic [AW-1:0]           match_idx_ff;
   logic [DW-1:0]           wtop_ff;
   logic [DW-1:0]           wbot_ff;
   logic [DW-1:0]           min_ff;
   logic [DW-1:0]           max_ff;
   logic signed [DW:0]      ovl_ff;
   logic signed [SUM_W-1:0] sum_ff;

   // Final values of the current transaction.
   logic [FW-1:0]           frac_ff;
   logic [DW-1:0]           fin_min_ff;
   logic [DW-1:0]           fin_max_ff;
   logic                    ovf_ff;

   logic                    rsp_valid_ff;
   logic [fit_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // Control outputs of the sequencer.
   logic                    accept;
   logic                    in_scan;
   logic                    in_add_end;
   logic                    in_qry_end;
   logic                    rsp_load;
   logic                    div_start;

   logic                    rd_en;
   logic [2*DW-1:0]         rd_data;
   logic [DW-1:0]           rd_top;
   logic [DW-1:0]           rd_bot;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [2*DW-1:0]         wr_data;

   logic                    is_add;
   logic                    contained;
   logic                    hit;
   logic                    keep;
   logic                    acc_en;
   logic                    ovl_skip;
   logic [DW-1:0]           clip_top;
   logic [DW-1:0]           clip_bot;
   logic signed [DW:0]      ovl;

   logic                    scan_done;
   logic                    append_ok;
   logic                    fold_en;
   logic [DW-1:0]           fold_top;
   logic [DW-1:0]           fold_bot;
   logic [DW-1:0]           fin_min;
   logic [DW-1:0]           fin_max;
   logic                    sum_pos;
   logic                    sum_full;
   logic                    need_div;
   logic                    rsp_free;

   logic                    div_done;
   logic [fit_pkg::FRAC_BITS-1:0] div_quo;

   fit_mem #(
      .DEPTH  (MAX_INTERVALS),
      .DATA_W (2 * DW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   fit_div #(
      .DW (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[DW-1:0]),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Entry evaluation, one memory word per cycle.
   always_comb begin
      rd_top = rd_data[DW-1:0];
      rd_bot = rd_data[2*DW-1:DW];
      is_add = (mode_ff == fit_pkg::MODE_ADD);
      contained = (new_top_ff <= rd_top) && (new_bot_ff >= rd_bot);
      hit = ((new_top_ff >= rd_top) && (new_top_ff <= rd_bot)) ||
            ((new_bot_ff <= rd_bot) && (new_bot_ff >= rd_top));
      keep = pend_ff && is_add && !contained;
      acc_en = pend_ff && (!is_add || !contained);
      ovl_skip = (rd_top > new_bot_ff) || (rd_bot < new_top_ff);
      clip_top = (new_top_ff > rd_top) ? new_top_ff : rd_top;
      clip_bot = (new_bot_ff < rd_bot) ? new_bot_ff : rd_bot;
      ovl = ovl_skip ? '0 : ($signed({1'b0, clip_bot}) - $signed({1'b0, clip_top}));
   end

   // End-of-scan folding shared by adds and queries.
   always_comb begin
      scan_done = (rd_cnt_ff == count_ff) && !pend_ff && !ovl_vld_ff;
      append_ok = kept_ff < CW'(MAX_INTERVALS);
      fold_en = is_add && (match_ff || append_ok);
      fold_top = match_ff ? wtop_ff : new_top_ff;
      fold_bot = match_ff ? wbot_ff : new_bot_ff;
      if (fold_en) begin
         fin_min = (any_ff && (min_ff < fold_top)) ? min_ff : fold_top;
         fin_max = (any_ff && (max_ff > fold_bot)) ? max_ff : fold_bot;
      end else begin
         fin_min = any_ff ? min_ff : '0;
         fin_max = any_ff ? max_ff : '0;
      end
      sum_pos = !sum_ff[SUM_W-1] && (sum_ff != '0);
      sum_full = $unsigned(sum_ff) >= SUM_W'(span_ff);
      need_div = span_ok_ff && sum_pos && !sum_full;
      rsp_free = !rsp_valid_ff || rsp_tready;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fit_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = fit_pkg::ST_SCAN;
            end
         end
         fit_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = is_add ? fit_pkg::ST_ADD_END : fit_pkg::ST_QRY_END;
            end
         end
         fit_pkg::ST_ADD_END: begin
            state_in = fit_pkg::ST_DONE;
         end
         fit_pkg::ST_QRY_END: begin
            state_in = need_div ? fit_pkg::ST_DIV : fit_pkg::ST_DONE;
         end
         fit_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = fit_pkg::ST_DONE;
            end
         end
         fit_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = fit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fit_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      in_scan = 1'b0;
      in_add_end = 1'b0;
      in_qry_end = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         fit_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         fit_pkg::ST_SCAN: begin
            in_scan = 1'b1;
         end
         fit_pkg::ST_ADD_END: begin
            in_add_end = 1'b1;
         end
         fit_pkg::ST_QRY_END: begin
            in_qry_end = 1'b1;
         end
         fit_pkg::ST_DIV: begin
         end
         fit_pkg::ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
      accept = req_tready && req_tvalid;
      div_start = in_qry_end && need_div;
      rd_en = in_scan && (rd_cnt_ff < count_ff);
   end

   // Compaction writes kept entries down in order; an add then widens, appends or drops.
   always_comb begin
      wr_en = (in_scan && keep) || (in_add_end && fold_en);
      wr_addr = (in_add_end && match_ff) ? match_idx_ff : kept_ff[AW-1:0];
      wr_data = in_add_end ? {fold_bot, fold_top} : rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fit_pkg::ST_IDLE;
         count_ff <= '0;
         rd_cnt_ff <= '0;
         pend_ff <= 1'b0;
         kept_ff <= '0;
         match_ff <= 1'b0;
         any_ff <= 1'b0;
         ovl_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= rd_en;
         ovl_vld_ff <= pend_ff && !is_add;
         if (accept) begin
            rd_cnt_ff <= '0;
            kept_ff <= '0;
            match_ff <= 1'b0;
            any_ff <= 1'b0;
         end else begin
            if (rd_en) begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
            end
            if (keep) begin
               kept_ff <= kept_ff + 1'b1;
               if (!match_ff && hit) begin
                  match_ff <= 1'b1;
               end
            end
            if (acc_en) begin
               any_ff <= 1'b1;
            end
         end
         if (in_add_end) begin
            count_ff <= (!match_ff && append_ok) ? kept_ff + 1'b1 : kept_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_tuser;
         new_top_ff <= DW'(req_tdata[FW-1:0]);
         new_bot_ff <= DW'(req_tdata[2*FW-1:FW]);
         span_ff <= DW'(req_tdata[2*FW-1:FW]) - DW'(req_tdata[FW-1:0]);
         span_ok_ff <= DW'(req_tdata[2*FW-1:FW]) > DW'(req_tdata[FW-1:0]);
         sum_ff <= '0;
      end else if (ovl_vld_ff) begin
         sum_ff <= sum_ff + SUM_W'(ovl_ff);
      end
      if (keep && !match_ff && hit) begin
         match_idx_ff <= kept_ff[AW-1:0];
         wtop_ff <= (new_top_ff < rd_top) ? new_top_ff : rd_top;
         wbot_ff <= (new_bot_ff > rd_bot) ? new_bot_ff : rd_bot;
      end
      if (acc_en) begin
         min_ff <= (any_ff && (min_ff < rd_top)) ? min_ff : rd_top;
         max_ff <= (any_ff && (max_ff > rd_bot)) ? max_ff : rd_bot;
      end
      ovl_ff <= ovl;
      if (in_add_end || in_qry_end) begin
         fin_min_ff <= fin_min;
         fin_max_ff <= fin_max;
         ovf_ff <= is_add && !fold_en;
      end
      if (in_add_end) begin
         frac_ff <= '0;
      end else if (in_qry_end) begin
         frac_ff <= (span_ok_ff && sum_pos && sum_full) ? fit_pkg::FRAC_ONE : '0;
      end else if (div_done) begin
         frac_ff <= FW'(div_quo);
      end
      if (rsp_load) begin
         rsp_data_ff <= {2'b00, ovf_ff, fit_pkg::COUNT_FIELD_W'(count_ff),
                         FW'(fin_max_ff), FW'(fin_min_ff), frac_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `FIT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `FIT_ASSERT_SAME(a_ovf_when_full, clock, reset, (state_ff == fit_pkg::ST_DONE) && ovf_ff, count_ff == CW'(MAX_INTERVALS))
   `FIT_ASSERT_SAME(a_div_done_in_div, clock, reset, div_done, state_ff == fit_pkg::ST_DIV)

endmodule

`default_nettype wire

// File: hdl/fit_mem.sv
`default_nettype none

module fit_mem #(
   parameter int DEPTH = fit_pkg::MAX_INTERVALS_DEF,
   parameter int DATA_W = 2 * fit_pkg::DEPTH_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/fit_div.sv
`default_nettype none

// Restoring divider for dividend < divisor, one quotient bit per cycle.
module fit_div #(
   parameter int DW = fit_pkg::DEPTH_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [DW-1:0]                dividend,
   input  wire logic [DW-1:0]                divisor,
   output logic                              done,
   output logic [fit_pkg::FRAC_BITS-1:0]     quotient
);

   localparam int SW = $clog2(fit_pkg::FRAC_BITS);

   logic                            busy_ff;
   logic                            done_ff;
   logic [SW-1:0]                   step_ff;
   logic [DW-1:0]                   rem_ff;
   logic [DW-1:0]                   div_ff;
   logic [fit_pkg::FRAC_BITS-1:0]   quo_ff;
   logic [DW:0]                     shifted;
   logic [DW:0]                     diff;
   logic                            fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff = shifted - {1'b0, div_ff};
      fits = shifted >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == SW'(fit_pkg::FRAC_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_ff <= {quo_ff[fit_pkg::FRAC_BITS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: bench/frozen_interval_table_tb.sv
`timescale 1ns / 100ps

module frozen_interval_table_tb;
   import fit_pkg::*;

   localparam int LENS_SLOTS = MAX_INTERVALS_DEF;
   localparam int DEPTH_MAX = (1 << FIELD_W) - 1;
   localparam int ITEM_TARGET = 1850;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 64;
   localparam int MAX_GAP = 13;
   localparam int LONG_STALL = 400;
   localparam int PRINT_CAP = 30;

   // Same layout as rsp_tdata, lowest field last.
   typedef struct packed {
      logic               overflow;
      logic [4:0]         entry_count;
      logic [FIELD_W-1:0] deepest_bottom;
      logic [FIELD_W-1:0] shallowest_top;
      logic [FIELD_W-1:0] frozen_fraction;
   } lens_report_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = MODE_ADD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Predicted contents of the lens table.
   logic [FIELD_W-1:0] lens_top [LENS_SLOTS];
   logic [FIELD_W-1:0] lens_bottom [LENS_SLOTS];
   int                 lens_count = 0;
   lens_report_t       pending_reports [$];

   int mismatches = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int adds_sent = 0;
   int queries_sent = 0;
   int overflows_seen = 0;
   int fullest_seen = 0;
   int sink_wait = 0;
   int sink_hold = 0;
   bit steady_flow = 1'b0;

   frozen_interval_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap();
      if (steady_flow)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic lens_report_t step_lens_table(logic mode, logic [FIELD_W-1:0] up_d,
                                                    logic [FIELD_W-1:0] lo_d);
      lens_report_t rep;
      int           i, kept, span, sum, near_d, far_d;
      bit           merged;
      rep = '0;
      if (mode == MODE_ADD) begin
         // Lenses that the new one covers completely are dropped; the rest keep their order.
         kept = 0;
         for (i = 0; i < lens_count; i++) begin
            if (!(up_d <= lens_top[i] && lo_d >= lens_bottom[i])) begin
               lens_top[kept] = lens_top[i];
               lens_bottom[kept] = lens_bottom[i];
               kept++;
            end
         end
         lens_count = kept;
         merged = 1'b0;
         for (i = 0; i < kept && !merged; i++) begin
            if ((up_d >= lens_top[i] && up_d <= lens_bottom[i]) ||
                (lo_d <= lens_bottom[i] && lo_d >= lens_top[i])) begin
               if (up_d < lens_top[i])
                  lens_top[i] = up_d;
               if (lo_d > lens_bottom[i])
                  lens_bottom[i] = lo_d;
               merged = 1'b1;
            end
         end
         if (!merged) begin
            if (kept < LENS_SLOTS) begin
               lens_top[kept] = up_d;
               lens_bottom[kept] = lo_d;
               lens_count = kept + 1;
            end else
               rep.overflow = 1'b1;
         end
      end else if (lo_d > up_d) begin
         span = lo_d - up_d;
         sum = 0;
         for (i = 0; i < lens_count; i++) begin
            if (lens_top[i] > lo_d || lens_bottom[i] < up_d)
               continue;
            near_d = (up_d > lens_top[i]) ? up_d : lens_top[i];
            far_d = (lo_d < lens_bottom[i]) ? lo_d : lens_bottom[i];
            // An inverted lens gives a negative overlap here.
            sum += far_d - near_d;
         end
         if (sum >= span)
            rep.frozen_fraction = FRAC_ONE;
         else if (sum > 0)
            rep.frozen_fraction = (longint'(sum) << FRAC_BITS) / span;
      end
      for (i = 0; i < lens_count; i++) begin
         if (i == 0 || lens_top[i] < rep.shallowest_top)
            rep.shallowest_top = lens_top[i];
         if (i == 0 || lens_bottom[i] > rep.deepest_bottom)
            rep.deepest_bottom = lens_bottom[i];
      end
      rep.entry_count = lens_count;
      return rep;
   endfunction

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // Offers one transaction and records its predicted report once it is taken.
   task automatic send_item(logic mode, logic [FIELD_W-1:0] up_d, logic [FIELD_W-1:0] lo_d);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {lo_d, up_d};
      do
         @(posedge clock);
      while (!req_tready);
      pending_reports.push_back(step_lens_table(mode, up_d, lo_d));
      items_sent++;
      if (mode == MODE_ADD)
         adds_sent++;
      else
         queries_sent++;
   endtask

   task automatic wait_for_reports();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_item(MODE_QUERY, 0, DEPTH_MAX);
      send_item(MODE_QUERY, DEPTH_MAX, DEPTH_MAX);
      send_item(MODE_QUERY, DEPTH_MAX, 0);
      wait_for_reports();
   endtask

   task automatic test_lens_merging();
      send_item(MODE_ADD, 100, 200);
      send_item(MODE_ADD, 300, 400);
      send_item(MODE_ADD, 150, 350);
      send_item(MODE_ADD, 90, 410);
      send_item(MODE_ADD, 1000, 900);
      send_item(MODE_QUERY, 800, 1100);
      send_item(MODE_QUERY, 0, 200);
      wait_for_reports();
   endtask

   task automatic test_table_overflow();
      int k;
      for (k = 1; k <= LENS_SLOTS - 2; k++)
         send_item(MODE_ADD, k * 4000, k * 4000 + 100);
      // The table is full and nothing matches, so this lens is dropped.
      send_item(MODE_ADD, DEPTH_MAX, DEPTH_MAX);
      send_item(MODE_QUERY, 0, DEPTH_MAX);
      wait_for_reports();
   endtask

   task automatic test_output_stall();
      int k;
      steady_flow = 1'b1;
      sink_hold = LONG_STALL;
      for (k = 0; k < 6; k++)
         send_item(MODE_QUERY, $urandom_range(0, 32767), $urandom_range(32768, DEPTH_MAX));
      send_item(MODE_ADD, 3990, 4200);
      steady_flow = 1'b0;
      wait_for_reports();
   endtask

   // Episodes work on one depth region so that adds meet, widen and swallow each other.
   task automatic test_random_episodes();
      int region, base, n, k, pick, top_d, bot_d;
      while (items_sent < ITEM_TARGET) begin
         steady_flow = ($urandom_range(0, 4) == 0);
         region = $urandom_range(1, 12) * 128;
         base = $urandom_range(0, DEPTH_MAX - region);
         n = $urandom_range(16, 40);
         for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               top_d = base + $urandom_range(0, region);
               bot_d = top_d + $urandom_range(0, 48);
               send_item(MODE_ADD, top_d, (bot_d > DEPTH_MAX) ? DEPTH_MAX : bot_d);
            end else if (pick < 72) begin
               top_d = base + $urandom_range(0, region);
               bot_d = top_d + $urandom_range(0, region);
               send_item(MODE_QUERY, top_d, (bot_d > DEPTH_MAX) ? DEPTH_MAX : bot_d);
            end else if (pick < 80) begin
               top_d = $urandom_range(1, DEPTH_MAX);
               bot_d = $urandom_range(0, top_d - 1);
               send_item(MODE_ADD, top_d, bot_d);
            end else if (pick < 92) begin
               send_item(MODE_QUERY, $urandom_range(0, DEPTH_MAX), $urandom_range(0, DEPTH_MAX));
            end else begin
               top_d = $urandom_range(0, DEPTH_MAX);
               bot_d = top_d + $urandom_range(0, 16);
               send_item(MODE_ADD, top_d, (bot_d > DEPTH_MAX) ? DEPTH_MAX : bot_d);
            end
         end
         if ($urandom_range(0, 2) == 0)
            send_item(MODE_ADD, base, base + region);
         if ($urandom_range(0, 5) == 0)
            wait_for_reports();
      end
      steady_flow = 1'b0;
   endtask

   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_hold--;
         rsp_tready <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait--;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin : check_reports
      lens_report_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(lens_report_t)-1:0];
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
               $display("%0t: unexpected transaction on the result channel, data %h",
                        $time, rsp_tdata);
         end else begin
            want = pending_reports.pop_front();
            compare_field("frozen_fraction", want.frozen_fraction, got.frozen_fraction);
            compare_field("shallowest_top", want.shallowest_top, got.shallowest_top);
            compare_field("deepest_bottom", want.deepest_bottom, got.deepest_bottom);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("overflow", want.overflow, got.overflow);
         end
         if (got.overflow)
            overflows_seen++;
         if (got.entry_count > fullest_seen)
            fullest_seen = got.entry_count;
         sink_wait = draw_gap();
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d reports outstanding",
               $time, cycle_count, pending_reports.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_lens_merging();
      test_table_overflow();
      test_output_stall();
      test_random_episodes();

      wait_for_reports();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d transactions (%0d adds, %0d queries) with random gaps and stalls.",
               items_sent, adds_sent, queries_sent);
      $display("Saw %0d dropped adds; the table held up to %0d lenses; %0d mismatches.",
               overflows_seen, fullest_seen, mismatches);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
